[rtl/core/wvs_pkg.sv]
// Shared types, constants and fixed-point helpers for the wave Verlet stencil step unit.
package wvs_pkg;

	localparam int VALUE_BITS = 48;
	localparam int OPER_BITS  = VALUE_BITS + 2;
	localparam int COEF_BITS  = 48;
	localparam int ACC_BITS   = OPER_BITS + COEF_BITS + 2;
	localparam int CHUNK_BITS = 16;
	localparam int CHUNKS     = (OPER_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int MAG_BITS   = CHUNKS * CHUNK_BITS;
	localparam int PROD_BITS  = MAG_BITS + COEF_BITS;
	localparam int CNT_BITS   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int COEF_FRAC  = 32;
	localparam int INV_FRAC   = 16;
	localparam int CFG_BITS   = 3;

	localparam logic [CFG_BITS-1:0] CFG_STEP_DT         = 3'd0;
	localparam logic [CFG_BITS-1:0] CFG_HALF_DT_SQUARED = 3'd1;
	localparam logic [CFG_BITS-1:0] CFG_HALF_DT         = 3'd2;
	localparam logic [CFG_BITS-1:0] CFG_INV_DX_SQUARED  = 3'd3;
	localparam logic [CFG_BITS-1:0] CFG_LEFT_EDGE_FIXED = 3'd4;
	localparam logic [CFG_BITS-1:0] CFG_RIGHT_EDGE_FREE = 3'd5;
	localparam logic [CFG_BITS-1:0] CFG_DERIVATIVE_ONLY = 3'd6;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [OPER_BITS-1:0]  oper_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic [COEF_BITS-1:0]         coef_t;

	typedef struct packed {
		value_t     position;
		value_t     velocity;
		value_t     accel;
		logic       first_point;
		logic       last_point;
		value_t     ghost_value;
	} item_t;

	typedef struct packed {
		value_t     new_position;
		value_t     new_velocity;
		value_t     new_accel;
		logic       end_of_sweep;
	} result_t;

	typedef struct packed {
		logic       start;
		logic       load;
		acc_t       addend;
		oper_t      operand;
		coef_t      coef;
	} mac_cmd_t;

	typedef struct packed {
		logic       done;
		acc_t       acc;
	} mac_rsp_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_MUL,
		MAC_FOLD
	} mac_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRED_X,
		ST_PRED_A,
		ST_HALF,
		ST_EDGE,
		ST_STEN,
		ST_KICK,
		ST_EMIT,
		ST_SHIFT
	} seq_state_t;

	function automatic oper_t widen(input value_t v);
		widen = {{(OPER_BITS-VALUE_BITS){v[VALUE_BITS-1]}}, v};
	endfunction

	function automatic acc_t shl32(input value_t v);
		shl32 = {{(ACC_BITS-VALUE_BITS-COEF_FRAC){v[VALUE_BITS-1]}}, v, {COEF_FRAC{1'b0}}};
	endfunction

	function automatic oper_t second_diff(input value_t l, input value_t c, input value_t r);
		oper_t cc;
		cc = widen(c);
		second_diff = widen(l) + widen(r) - (cc <<< 1);
	endfunction

	function automatic value_t round_sat(input acc_t a, input logic coarse);
		acc_t t;
		acc_t s;
		logic [ACC_BITS-VALUE_BITS:0] hi;
		t = a + (coarse ? (acc_t'(1) <<< (COEF_FRAC-1)) : (acc_t'(1) <<< (INV_FRAC-1)));
		s = coarse ? (t >>> COEF_FRAC) : (t >>> INV_FRAC);
		hi = s[ACC_BITS-1:VALUE_BITS-1];
		if (&hi || ~|hi) begin
			round_sat = s[VALUE_BITS-1:0];
		end else if (s[ACC_BITS-1]) begin
			round_sat = {1'b1, {(VALUE_BITS-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(VALUE_BITS-1){1'b1}}};
		end
	endfunction

endpackage

[rtl/core/wave_verlet_stencil_step_unit.sv]
// Top level: sequencer, sweep state, configuration and result register of the stencil step.
// Each grid point runs its products in turn through the single 16x48-bit multiplier: every
// product takes four passes plus a fold and a handoff, and a point needs up to five products
// (three predictor products, the stencil and the velocity kick), two more for the extra result
// at the end of a sweep. In derivative-only mode at most the stencil product runs. The block
// takes a new point while the previous result still waits in its output register.
module wave_verlet_stencil_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  wvs_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output wvs_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wvs_pkg::CFG_BITS-1:0]  cfg_index,
	input  logic [wvs_pkg::COEF_BITS-1:0] cfg_data
);
	import wvs_pkg::*;

	seq_state_t state_q, state_d;
	mac_cmd_t   mac_cmd;
	mac_rsp_t   mac_rsp;

	logic [31:0]    dt_q, hdt2_q, hdt_q;
	coef_t          invdx2_q;
	logic           lfix_q, rfree_q, donly_q;

	item_t          item_q;
	value_t         p_q, hv_q, older_q, pend_p_q, pend_v_q, lghost_q, acc_q, vel_q;
	logic           pend_valid_q, pend_first_q, tail_q, wait_q;
	logic           out_valid_q;
	result_t        out_q;

	logic           accept, out_free, emit0, zero_acc;
	value_t         left, center, right, cv, rounded;

	assign accept    = item_valid && item_ready;
	assign out_free  = !out_valid_q || result_ready;
	assign cfg_ready = 1'b1;
	assign emit0     = pend_valid_q && !item_q.first_point;
	assign left      = pend_first_q ? lghost_q : older_q;
	assign center    = tail_q ? p_q : pend_p_q;
	assign right     = tail_q ? (rfree_q ? left : item_q.ghost_value) : p_q;
	assign cv        = tail_q ? hv_q : pend_v_q;
	assign zero_acc  = pend_first_q && lfix_q && (!tail_q || !rfree_q);
	assign rounded   = round_sat(mac_rsp.acc, state_q != ST_STEN);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = donly_q ? ST_EDGE : ST_PRED_X;
			ST_PRED_X: if (mac_rsp.done) state_d = ST_PRED_A;
			ST_PRED_A: if (mac_rsp.done) state_d = ST_HALF;
			ST_HALF:   if (mac_rsp.done) state_d = ST_EDGE;
			ST_EDGE: begin
				if (!tail_q && !emit0) state_d = ST_SHIFT;
				else if (zero_acc) state_d = ST_KICK;
				else state_d = ST_STEN;
			end
			ST_STEN:   if (mac_rsp.done) state_d = ST_KICK;
			ST_KICK:   if (donly_q || mac_rsp.done) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = tail_q ? ST_IDLE : ST_SHIFT;
			ST_SHIFT:  state_d = item_q.last_point ? ST_EDGE : ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready      = 1'b0;
		mac_cmd.start   = 1'b0;
		mac_cmd.load    = 1'b1;
		mac_cmd.addend  = '0;
		mac_cmd.operand = '0;
		mac_cmd.coef    = '0;
		case (state_q)
			ST_IDLE: item_ready = 1'b1;
			ST_PRED_X: begin
				mac_cmd.start   = !wait_q;
				mac_cmd.addend  = shl32(item_q.position);
				mac_cmd.operand = widen(item_q.velocity);
				mac_cmd.coef    = COEF_BITS'(dt_q);
			end
			ST_PRED_A: begin
				mac_cmd.start   = !wait_q;
				mac_cmd.load    = 1'b0;
				mac_cmd.operand = widen(item_q.accel);
				mac_cmd.coef    = COEF_BITS'(hdt2_q);
			end
			ST_HALF: begin
				mac_cmd.start   = !wait_q;
				mac_cmd.addend  = shl32(item_q.velocity);
				mac_cmd.operand = widen(item_q.accel);
				mac_cmd.coef    = COEF_BITS'(hdt_q);
			end
			ST_STEN: begin
				mac_cmd.start   = !wait_q;
				mac_cmd.operand = second_diff(left, center, right);
				mac_cmd.coef    = invdx2_q;
			end
			ST_KICK: begin
				mac_cmd.start   = !wait_q && !donly_q;
				mac_cmd.addend  = shl32(cv);
				mac_cmd.operand = widen(acc_q);
				mac_cmd.coef    = COEF_BITS'(hdt_q);
			end
			default: ;
		endcase
	end

	wvs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.rsp    (mac_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wait_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_first_q <= 1'b0;
			tail_q       <= 1'b0;
			older_q      <= '0;
			pend_p_q     <= '0;
			pend_v_q     <= '0;
			lghost_q     <= '0;
			dt_q         <= 32'd42949673;
			hdt2_q       <= 32'd214748;
			hdt_q        <= 32'd21474836;
			invdx2_q     <= COEF_BITS'(65536);
			lfix_q       <= 1'b1;
			rfree_q      <= 1'b1;
			donly_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mac_cmd.start) wait_q <= 1'b1;
			else if (mac_rsp.done) wait_q <= 1'b0;
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (result_valid && result_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STEP_DT:         dt_q     <= cfg_data[31:0];
					CFG_HALF_DT_SQUARED: hdt2_q   <= cfg_data[31:0];
					CFG_HALF_DT:         hdt_q    <= cfg_data[31:0];
					CFG_INV_DX_SQUARED:  invdx2_q <= cfg_data;
					CFG_LEFT_EDGE_FIXED: lfix_q   <= cfg_data[0];
					CFG_RIGHT_EDGE_FREE: rfree_q  <= cfg_data[0];
					CFG_DERIVATIVE_ONLY: donly_q  <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: tail_q <= 1'b0;
				ST_EDGE: begin
					if (!tail_q && !emit0) begin
						lghost_q     <= item_q.ghost_value;
						pend_first_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pend_first_q <= 1'b0;
						if (tail_q) pend_valid_q <= 1'b0;
						else older_q <= pend_p_q;
					end
				end
				ST_SHIFT: begin
					pend_p_q     <= p_q;
					pend_v_q     <= hv_q;
					pend_valid_q <= 1'b1;
					tail_q       <= item_q.last_point;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			p_q    <= item.position;
			hv_q   <= item.velocity;
		end
		if (state_q == ST_PRED_A && mac_rsp.done) p_q <= rounded;
		if (state_q == ST_HALF && mac_rsp.done) hv_q <= rounded;
		if (state_q == ST_EDGE && zero_acc) acc_q <= '0;
		if (state_q == ST_STEN && mac_rsp.done) acc_q <= rounded;
		if (state_q == ST_KICK) vel_q <= donly_q ? cv : rounded;
		if (state_q == ST_EMIT && out_free) begin
			out_q.new_position <= center;
			out_q.new_velocity <= vel_q;
			out_q.new_accel    <= acc_q;
			out_q.end_of_sweep <= tail_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.done |-> wait_q)
		else $error("multiplier result without a pending request");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !wait_q)
		else $error("item taken while a product is in flight");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("second item taken before the sequence ran");

endmodule

[rtl/core/wvs_mac.sv]
// Shared multiply-accumulate unit: signed operand times unsigned coefficient, 16 bits a pass.
module wvs_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  wvs_pkg::mac_cmd_t cmd,
	output wvs_pkg::mac_rsp_t rsp
);
	import wvs_pkg::*;

	mac_state_t            state_q, state_d;
	logic [MAG_BITS-1:0]   mag_q;
	coef_t                 coef_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic                  neg_q;
	logic [CNT_BITS-1:0]   cnt_q;
	acc_t                  acc_q;
	logic                  done_q;
	logic [OPER_BITS-1:0]  op_abs;
	logic [CHUNK_BITS+COEF_BITS-1:0] part;
	acc_t                  prod_t;
	logic                  take, mul_en, fold_en;

	assign op_abs = cmd.operand[OPER_BITS-1] ? OPER_BITS'(-cmd.operand) : cmd.operand;
	assign part   = mag_q[MAG_BITS-1 -: CHUNK_BITS] * coef_q;
	assign prod_t = prod_q[ACC_BITS-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			MAC_IDLE: if (cmd.start) state_d = MAC_MUL;
			MAC_MUL:  if (cnt_q == '0) state_d = MAC_FOLD;
			MAC_FOLD: state_d = MAC_IDLE;
			default:  state_d = MAC_IDLE;
		endcase
	end

	always_comb begin
		take    = 1'b0;
		mul_en  = 1'b0;
		fold_en = 1'b0;
		case (state_q)
			MAC_IDLE: take = cmd.start;
			MAC_MUL:  mul_en = 1'b1;
			MAC_FOLD: fold_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MAC_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fold_en;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mag_q  <= MAG_BITS'(op_abs);
			coef_q <= cmd.coef;
			neg_q  <= cmd.operand[OPER_BITS-1];
			prod_q <= '0;
			cnt_q  <= CNT_BITS'(CHUNKS - 1);
			if (cmd.load) acc_q <= cmd.addend;
		end
		if (mul_en) begin
			prod_q <= (prod_q << CHUNK_BITS) + PROD_BITS'(part);
			mag_q  <= mag_q << CHUNK_BITS;
			cnt_q  <= cnt_q - 1'b1;
		end
		if (fold_en) acc_q <= neg_q ? (acc_q - prod_t) : (acc_q + prod_t);
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;

endmodule
